// File: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared constants and the result word type of the scan frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Default largest frame (header and payload, checksum not counted), in bytes
  localparam int unsigned MAX_FRAME_DEF = 1024;

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned STATUS_BYTES = 5;

  // Stored status after reset
  localparam logic [15:0] SAMPLES_RST = 16'd200;
  localparam logic [15:0] PERIOD_RST  = 16'd250;
  localparam logic [7:0]  FLAGS_RST   = 8'd0;

  // Frame type codes
  localparam logic [7:0] TYPE_RANGE  = 8'd0;
  localparam logic [7:0] TYPE_STATUS = 8'd1;

  // Result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  // End status codes
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic        result_kind;
    logic [8:0]  sample_index;
    logic [15:0] range_mm;
    logic [7:0]  frame_type;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;
    logic        status_updated;
    logic [15:0] scan_samples;
    logic [15:0] scan_period_ms;
    logic [7:0]  status_flags;
  } result_t;

endpackage

// File: rtl/sfp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_ifs
// Byte input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [8:0]  sample_index;
  logic [15:0] range_mm;
  logic [7:0]  frame_type;
  logic [1:0]  frame_status;
  logic [15:0] frame_length;
  logic        status_updated;
  logic [15:0] scan_samples;
  logic [15:0] scan_period_ms;
  logic [7:0]  status_flags;

  modport source (output valid, input ready, output result_kind, output sample_index,
                  output range_mm, output frame_type, output frame_status,
                  output frame_length, output status_updated, output scan_samples,
                  output scan_period_ms, output status_flags);
  modport sink   (input valid, output ready, input result_kind, input sample_index,
                  input range_mm, input frame_type, input frame_status,
                  input frame_length, input status_updated, input scan_samples,
                  input scan_period_ms, input status_flags);
endinterface

// File: rtl/sfp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_in_reg
// Input register: holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
module sfp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  sfp_byte_if.sink   in_bus,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       load;

  // Take a new word when empty or when the held word moves on
  assign in_bus.ready = !valid_r || advance;
  assign load         = in_bus.valid && in_bus.ready;
  assign valid_nxt    = in_bus.ready ? in_bus.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_bus.rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

// File: rtl/sfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_parser
// Frame state machine: sync hunt, header, payload, checksum; emits range
// samples and frame end words, and keeps the committed scanner status.
// ----------------------------------------------------------------------------
module sfp_parser #(
  parameter int unsigned MAX_FRAME = sfp_pkg::MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             emit,
  output sfp_pkg::result_t res
);
  import sfp_pkg::*;

  localparam int unsigned PCW = $clog2(MAX_FRAME);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_LEN_LO  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CHECK   = 3'd6;

  logic [2:0]     phase_r, phase_nxt;
  logic [7:0]     type_r, type_nxt;
  logic [15:0]    len_r, len_nxt;
  logic [PCW-1:0] count_r, count_nxt;
  logic [7:0]     sum_r, sum_nxt;
  logic [7:0]     low_r, low_nxt;
  logic [39:0]    pend_r, pend_nxt;
  logic [15:0]    samples_r, samples_nxt;
  logic [15:0]    period_r, period_nxt;
  logic [7:0]     flags_r, flags_nxt;

  logic [7:0]     sum_add;
  logic [15:0]    len_full;
  logic [PCW-1:0] count_inc;
  logic [16:0]    pos_x;
  logic           too_long;
  logic           overrun;
  logic           good;

  logic           emit_c;
  logic           kind_c;
  logic [8:0]     index_c;
  logic [15:0]    range_c;
  logic [1:0]     status_c;
  logic           updated_c;

  assign sum_add   = sum_r + rx_byte;
  assign len_full  = {len_r[15:8], rx_byte};
  assign count_inc = count_r + 1'b1;
  assign pos_x     = 17'(count_r);
  assign too_long  = {1'b0, len_full} >= 17'(MAX_FRAME);
  assign overrun   = (pos_x + 17'(HEADER_BYTES)) >= 17'(MAX_FRAME);
  assign good      = (rx_byte == ~sum_r);

  // One parser step per word
  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    low_nxt     = low_r;
    pend_nxt    = pend_r;
    samples_nxt = samples_r;
    period_nxt  = period_r;
    flags_nxt   = flags_r;
    emit_c      = 1'b0;
    kind_c      = KIND_END;
    index_c     = 9'd0;
    range_c     = 16'd0;
    status_c    = ST_GOOD;
    updated_c   = 1'b0;

    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == SYNC_BYTE) begin
          sum_nxt   = rx_byte;
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_BYTE) begin
          sum_nxt   = sum_add;
          phase_nxt = PH_TYPE;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_TYPE: begin
        sum_nxt   = sum_add;
        type_nxt  = rx_byte;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_nxt   = sum_add;
        len_nxt   = {rx_byte, 8'h00};
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_nxt   = sum_add;
        len_nxt   = len_full;
        count_nxt = '0;
        pend_nxt  = '0;
        low_nxt   = 8'd0;
        if (too_long) begin
          phase_nxt = PH_HUNT;
          emit_c    = 1'b1;
          status_c  = ST_TOO_LONG;
        end else begin
          phase_nxt = (len_full != 16'd0) ? PH_PAYLOAD : PH_CHECK;
        end
      end
      PH_PAYLOAD: begin
        if (overrun) begin
          // byte would lie beyond the largest frame (MAX_FRAME bytes)
          phase_nxt = PH_HUNT;
          emit_c    = 1'b1;
          status_c  = ST_TOO_LONG;
        end else begin
          sum_nxt   = sum_add;
          count_nxt = count_inc;
          if (17'(count_inc) >= {1'b0, len_r}) begin
            phase_nxt = PH_CHECK;
          end
          if (type_r == TYPE_RANGE) begin
            if (!count_r[0]) begin
              low_nxt = rx_byte;
            end else begin
              emit_c  = 1'b1;
              kind_c  = KIND_SAMPLE;
              index_c = pos_x[9:1];
              range_c = {rx_byte, low_r};
            end
          end else if (type_r == TYPE_STATUS && pos_x < 17'(STATUS_BYTES)) begin
            pend_nxt[{count_r[2:0], 3'b000} +: 8] = rx_byte;
          end
        end
      end
      PH_CHECK: begin
        phase_nxt = PH_HUNT;
        emit_c    = 1'b1;
        status_c  = good ? ST_GOOD : ST_BAD_SUM;
        if (good && type_r == TYPE_STATUS) begin
          samples_nxt = pend_r[15:0];
          period_nxt  = pend_r[31:16];
          flags_nxt   = pend_r[39:32];
          updated_c   = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  // Result word carries the values after this step
  always_comb begin
    res.result_kind    = kind_c;
    res.sample_index   = index_c;
    res.range_mm       = range_c;
    res.frame_type     = type_nxt;
    res.frame_status   = status_c;
    res.frame_length   = len_nxt;
    res.status_updated = updated_c;
    res.scan_samples   = samples_nxt;
    res.scan_period_ms = period_nxt;
    res.status_flags   = flags_nxt;
  end

  assign emit = step && emit_c;

  // State update, only when a word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      type_r    <= 8'd0;
      len_r     <= 16'd0;
      count_r   <= '0;
      sum_r     <= 8'd0;
      low_r     <= 8'd0;
      pend_r    <= '0;
      samples_r <= SAMPLES_RST;
      period_r  <= PERIOD_RST;
      flags_r   <= FLAGS_RST;
    end else if (step) begin
      phase_r   <= phase_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
      low_r     <= low_nxt;
      pend_r    <= pend_nxt;
      samples_r <= samples_nxt;
      period_r  <= period_nxt;
      flags_r   <= flags_nxt;
    end
  end

endmodule

// File: rtl/sfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module sfp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             emit,
  input  sfp_pkg::result_t res,
  output logic             advance,
  sfp_result_if.source     out_bus
);
  import sfp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // Register is free when empty or being drained this cycle
  assign advance   = !valid_r || out_bus.ready;
  assign valid_nxt = advance ? emit : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      data_r <= res;
    end
  end

  assign out_bus.valid          = valid_r;
  assign out_bus.result_kind    = data_r.result_kind;
  assign out_bus.sample_index   = data_r.sample_index;
  assign out_bus.range_mm       = data_r.range_mm;
  assign out_bus.frame_type     = data_r.frame_type;
  assign out_bus.frame_status   = data_r.frame_status;
  assign out_bus.frame_length   = data_r.frame_length;
  assign out_bus.status_updated = data_r.status_updated;
  assign out_bus.scan_samples   = data_r.scan_samples;
  assign out_bus.scan_period_ms = data_r.scan_period_ms;
  assign out_bus.status_flags   = data_r.status_flags;

endmodule

// File: rtl/scan_frame_parser_unit.sv
`timescale 1ns / 1ps
// A word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; the single parser step between the input
// register and the result register sets this, and stalls only follow out_bus.ready.
// Reset (rst_n low, synchronous): parser hunts for sync, both registers empty,
// stored status returns to 200 samples per scan, 250 ms period, flags 0.
// ----------------------------------------------------------------------------
// scan_frame_parser_unit
// Parses FF FF / type / length / payload / checksum frames from a byte stream.
// ----------------------------------------------------------------------------
module scan_frame_parser_unit #(
  parameter int unsigned MAX_FRAME = sfp_pkg::MAX_FRAME_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sfp_byte_if.sink     in_bus,
  sfp_result_if.source out_bus
);
  import sfp_pkg::*;

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       emit;
  result_t    res;

  // Input word register
  sfp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Frame parser
  sfp_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (byte_valid && advance),
    .rx_byte (byte_data),
    .emit    (emit),
    .res     (res)
  );

  // Result word register
  sfp_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .emit    (emit),
    .res     (res),
    .advance (advance),
    .out_bus (out_bus)
  );

endmodule
